// File: rtl/cthd_pkg.sv
// Shared types and constants for the cook timer / heater duty controller.
// No dependencies; imported by the interfaces and all modules.
package cthd_pkg;

  localparam int HOURS_W = 3;
  localparam int MS_W    = 6;
  localparam int TEMP_W  = 9;
  localparam int DUTY_W  = 4;
  localparam int HYST_W  = 3;
  localparam int OP_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam int SLOTS_PER_CYCLE_DEF = 10;

  localparam logic [HOURS_W-1:0] MAX_HOURS = 3'd5;
  localparam logic [MS_W-1:0]    MAX_MS    = 6'd59;
  localparam logic [DUTY_W-1:0]  DUTY_MIN  = 4'd5;
  localparam logic [DUTY_W-1:0]  DUTY_MAX  = 4'd10;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_SEC   = 3'd3,
    OP_HEAT  = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AUTO_MODE   = 2'd0,
    REG_HYSTERESIS  = 2'd1,
    REG_MANUAL_DUTY = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              auto_mode;
    logic [HYST_W-1:0] hysteresis_degrees;
    logic [DUTY_W-1:0] manual_duty;
  } cfg_t;

endpackage

// File: rtl/cthd_cmd_if.sv
// Command channel: valid/ready handshake plus one command item.
// Depends on cthd_pkg for field widths.
interface cthd_cmd_if;
  import cthd_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [HOURS_W-1:0] load_hours;
  logic [MS_W-1:0]    load_minutes;
  logic [MS_W-1:0]    load_seconds;
  logic [TEMP_W-1:0]  measured_temp;
  logic [TEMP_W-1:0]  setpoint_temp;

  modport source (
    output valid, op, load_hours, load_minutes, load_seconds,
           measured_temp, setpoint_temp,
    input  ready
  );
  modport sink (
    input  valid, op, load_hours, load_minutes, load_seconds,
           measured_temp, setpoint_temp,
    output ready
  );
endinterface

// File: rtl/cthd_status_if.sv
// Status channel: valid/ready handshake plus one status item.
// Depends on cthd_pkg for field widths.
interface cthd_status_if;
  import cthd_pkg::*;

  logic               valid;
  logic               ready;
  logic               heater_on;
  logic               cooking_active;
  logic               buzzer;
  logic [HOURS_W-1:0] hours_left;
  logic [MS_W-1:0]    minutes_left;
  logic [MS_W-1:0]    seconds_left;
  logic [DUTY_W-1:0]  duty_now;

  modport source (
    output valid, heater_on, cooking_active, buzzer, hours_left,
           minutes_left, seconds_left, duty_now,
    input  ready
  );
  modport sink (
    input  valid, heater_on, cooking_active, buzzer, hours_left,
           minutes_left, seconds_left, duty_now,
    output ready
  );
endinterface

// File: rtl/cthd_heater.sv
// Time-proportioned heater: slot counter, auto duty register and the
// per-slot heater decision. Depends on cthd_pkg.
module cthd_heater #(
  parameter int SLOTS_PER_CYCLE = cthd_pkg::SLOTS_PER_CYCLE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tick,
  input  cthd_pkg::cfg_t                      cfg,
  input  logic                                cooking,
  input  logic                                heater_level,
  input  logic [cthd_pkg::TEMP_W-1:0]         measured_temp,
  input  logic [cthd_pkg::TEMP_W-1:0]         setpoint_temp,
  output logic                                heater_tick_level,
  output logic [cthd_pkg::DUTY_W-1:0]         auto_duty_next
);
  import cthd_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS_PER_CYCLE + 1);
  localparam int CMP_W  = (SLOT_W > DUTY_W) ? SLOT_W : DUTY_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS_PER_CYCLE);

  logic [SLOT_W-1:0]   slot_index, slot_index_next;
  logic [DUTY_W-1:0]   auto_duty;
  logic [DUTY_W-1:0]   duty_sel;
  logic [DUTY_W-1:0]   duty_clamped;
  logic signed [TEMP_W:0] err;
  logic                over_limit;
  logic                force_off;

  always_comb begin
    err = $signed({1'b0, setpoint_temp}) - $signed({1'b0, measured_temp});
    if (err > $signed({{(TEMP_W-DUTY_W+1){1'b0}}, DUTY_MAX})) begin
      duty_clamped = DUTY_MAX;
    end else if (err < $signed({{(TEMP_W-DUTY_W+1){1'b0}}, DUTY_MIN})) begin
      duty_clamped = DUTY_MIN;
    end else begin
      duty_clamped = err[DUTY_W-1:0];
    end
    over_limit = {1'b0, measured_temp} >
                 ({1'b0, setpoint_temp} + {{(TEMP_W-HYST_W+1){1'b0}}, cfg.hysteresis_degrees});
  end

  always_comb begin
    auto_duty_next    = auto_duty;
    slot_index_next   = slot_index;
    heater_tick_level = heater_level;
    force_off         = 1'b0;
    duty_sel          = cfg.manual_duty;
    if (tick) begin
      if (!cooking) begin
        heater_tick_level = 1'b0;
      end else begin
        if (cfg.auto_mode) begin
          if (over_limit) begin
            force_off = 1'b1;
            duty_sel  = auto_duty;
          end else begin
            auto_duty_next = duty_clamped;
            duty_sel       = duty_clamped;
          end
        end
        // slot zero is idle: heater keeps its level unless forced off
        if (slot_index != '0) begin
          heater_tick_level = CMP_W'(slot_index) <= CMP_W'(duty_sel);
        end
        if (force_off) begin
          heater_tick_level = 1'b0;
        end
        slot_index_next = (slot_index >= SLOT_LAST) ? '0 : slot_index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index <= '0;
      auto_duty  <= '0;
    end else begin
      slot_index <= slot_index_next;
      auto_duty  <= auto_duty_next;
    end
  end

endmodule

// File: rtl/cook_timer_heater_duty_control.sv
// Cook timer with time-proportioned heater duty control.
// The status item is registered: its valid rises in the cycle after an item is accepted.
// Throughput: 1 item per cycle; the status register parts the two sides,
// so a new item is taken whenever the status register is empty or drained.
// Reset (rst, synchronous): timer, flags, slot, duty and config clear to 0.
// Depends on cthd_pkg, cthd_cmd_if, cthd_status_if and cthd_heater.
module cook_timer_heater_duty_control #(
  parameter int SLOTS_PER_CYCLE = cthd_pkg::SLOTS_PER_CYCLE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cthd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cthd_pkg::CFG_DATA_W-1:0]   cfg_data,
  cthd_cmd_if.sink                          cmd,
  cthd_status_if.source                     status
);
  import cthd_pkg::*;

  cfg_t cfg;

  logic [HOURS_W-1:0] hours_count, hours_count_next;
  logic [MS_W-1:0]    minutes_count, minutes_count_next;
  logic [MS_W-1:0]    seconds_count, seconds_count_next;
  logic               cooking_flag, cooking_flag_next;
  logic               buzzer_flag, buzzer_flag_next;
  logic               heater_level, heater_level_next;

  logic               accept;
  logic               heat_tick;
  logic               time_zero;
  logic               heater_tick_level;
  logic [DUTY_W-1:0]  auto_duty_next;
  op_t                op;

  assign cmd.ready = !status.valid || status.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign op        = op_t'(cmd.op);
  assign heat_tick = accept && (op == OP_HEAT);
  assign time_zero = (hours_count == '0) && (minutes_count == '0) &&
                     (seconds_count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AUTO_MODE:   cfg.auto_mode          <= cfg_data[0];
        REG_HYSTERESIS:  cfg.hysteresis_degrees <= cfg_data[HYST_W-1:0];
        REG_MANUAL_DUTY: cfg.manual_duty        <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  cthd_heater #(
    .SLOTS_PER_CYCLE (SLOTS_PER_CYCLE)
  ) u_heater (
    .clk               (clk),
    .rst               (rst),
    .tick              (heat_tick),
    .cfg               (cfg),
    .cooking           (cooking_flag),
    .heater_level      (heater_level),
    .measured_temp     (cmd.measured_temp),
    .setpoint_temp     (cmd.setpoint_temp),
    .heater_tick_level (heater_tick_level),
    .auto_duty_next    (auto_duty_next)
  );

  always_comb begin
    hours_count_next   = hours_count;
    minutes_count_next = minutes_count;
    seconds_count_next = seconds_count;
    cooking_flag_next  = cooking_flag;
    buzzer_flag_next   = buzzer_flag;
    heater_level_next  = heater_level;
    if (accept) begin
      unique case (op)
        OP_LOAD: begin
          hours_count_next   = (cmd.load_hours > MAX_HOURS) ? MAX_HOURS : cmd.load_hours;
          minutes_count_next = (cmd.load_minutes > MAX_MS) ? MAX_MS : cmd.load_minutes;
          seconds_count_next = (cmd.load_seconds > MAX_MS) ? MAX_MS : cmd.load_seconds;
        end
        OP_START: begin
          if (!time_zero) begin
            cooking_flag_next = 1'b1;
            heater_level_next = 1'b1;
            buzzer_flag_next  = 1'b0;
          end
        end
        OP_STOP: begin
          cooking_flag_next = 1'b0;
          heater_level_next = 1'b0;
        end
        OP_SEC: begin
          if (cooking_flag) begin
            if (time_zero) begin
              buzzer_flag_next  = 1'b1;
              cooking_flag_next = 1'b0;
              heater_level_next = 1'b0;
            end else if (seconds_count != '0) begin
              seconds_count_next = seconds_count - 1'b1;
            end else begin
              // borrow from minutes, then hours
              seconds_count_next = MAX_MS;
              if (minutes_count != '0) begin
                minutes_count_next = minutes_count - 1'b1;
              end else begin
                minutes_count_next = MAX_MS;
                hours_count_next   = hours_count - 1'b1;
              end
            end
          end
        end
        OP_HEAT: heater_level_next = heater_tick_level;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hours_count   <= '0;
      minutes_count <= '0;
      seconds_count <= '0;
      cooking_flag  <= 1'b0;
      buzzer_flag   <= 1'b0;
      heater_level  <= 1'b0;
      status.valid  <= 1'b0;
    end else begin
      hours_count   <= hours_count_next;
      minutes_count <= minutes_count_next;
      seconds_count <= seconds_count_next;
      cooking_flag  <= cooking_flag_next;
      buzzer_flag   <= buzzer_flag_next;
      heater_level  <= heater_level_next;
      if (accept) begin
        status.valid <= 1'b1;
      end else if (status.ready) begin
        status.valid <= 1'b0;
      end
    end
  end

  // status payload, loaded with the post-item state
  always_ff @(posedge clk) begin
    if (accept) begin
      status.heater_on      <= heater_level_next;
      status.cooking_active <= cooking_flag_next;
      status.buzzer         <= buzzer_flag_next;
      status.hours_left     <= hours_count_next;
      status.minutes_left   <= minutes_count_next;
      status.seconds_left   <= seconds_count_next;
      status.duty_now       <= cfg.auto_mode ? auto_duty_next : cfg.manual_duty;
    end
  end

endmodule

// File: test/cook_timer_heater_duty_control_test.sv
// Self-checking testbench for cook_timer_heater_duty_control: a queue-fed driver,
// a monitor that scores status items against an in-bench predictor.
// Depends on cthd_pkg, cthd_cmd_if, cthd_status_if and the block itself.
module cook_timer_heater_duty_control_test;
  import cthd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 50;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [HOURS_W-1:0] hours;
    logic [MS_W-1:0]    minutes;
    logic [MS_W-1:0]    seconds;
    logic [TEMP_W-1:0]  temp;
    logic [TEMP_W-1:0]  setp;
  } cmd_item_t;

  typedef struct {
    logic               heater_on;
    logic               cooking_active;
    logic               buzzer;
    logic [HOURS_W-1:0] hours_left;
    logic [MS_W-1:0]    minutes_left;
    logic [MS_W-1:0]    seconds_left;
    logic [DUTY_W-1:0]  duty_now;
  } status_item_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cthd_cmd_if    cmd_ch();
  cthd_status_if status_ch();

  cook_timer_heater_duty_control i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .status    (status_ch)
  );

  // pending commands and expected status items
  cmd_item_t    cmd_backlog[$];
  status_item_t status_expected[$];
  int queued_total   = 0;
  int accepted_total = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // predictor copy of config and state
  logic                 cfg_auto = 1'b0;
  logic [HYST_W-1:0]    cfg_hyst = '0;
  logic [DUTY_W-1:0]    cfg_duty = '0;
  logic [HOURS_W-1:0]   tmr_hours = '0;
  logic [MS_W-1:0]      tmr_minutes = '0;
  logic [MS_W-1:0]      tmr_seconds = '0;
  logic                 cook_on = 1'b0;
  logic                 buzz_on = 1'b0;
  logic [3:0]           slot_pos = '0;
  logic [DUTY_W-1:0]    auto_duty_q = '0;
  logic                 heater_q = 1'b0;

  cmd_item_t    drv_next;
  cmd_item_t    drv_taken;
  status_item_t drv_status;
  status_item_t mon_want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic step_slot(input logic [DUTY_W-1:0] duty, input bit force_off);
    if (slot_pos != 0) heater_q = (slot_pos <= duty);
    if (force_off) heater_q = 1'b0;
    if (slot_pos >= SLOTS_PER_CYCLE_DEF) slot_pos = '0;
    else slot_pos = slot_pos + 4'd1;
  endtask

  task automatic predict_status(input cmd_item_t c, output status_item_t s);
    int err;
    case (c.op)
      OP_LOAD: begin
        tmr_hours   = (c.hours > MAX_HOURS) ? MAX_HOURS : c.hours;
        tmr_minutes = (c.minutes > MAX_MS) ? MAX_MS : c.minutes;
        tmr_seconds = (c.seconds > MAX_MS) ? MAX_MS : c.seconds;
      end
      OP_START: begin
        if (tmr_hours != 0 || tmr_minutes != 0 || tmr_seconds != 0) begin
          cook_on  = 1'b1;
          heater_q = 1'b1;
          buzz_on  = 1'b0;
        end
      end
      OP_STOP: begin
        cook_on  = 1'b0;
        heater_q = 1'b0;
      end
      OP_SEC: begin
        if (cook_on) begin
          if (tmr_hours == 0 && tmr_minutes == 0 && tmr_seconds == 0) begin
            buzz_on  = 1'b1;
            cook_on  = 1'b0;
            heater_q = 1'b0;
          end else if (tmr_seconds != 0) begin
            tmr_seconds = tmr_seconds - 1'b1;
          end else begin
            tmr_seconds = MAX_MS;
            if (tmr_minutes != 0) begin
              tmr_minutes = tmr_minutes - 1'b1;
            end else begin
              tmr_minutes = MAX_MS;
              if (tmr_hours != 0) tmr_hours = tmr_hours - 1'b1;
            end
          end
        end
      end
      OP_HEAT: begin
        if (!cook_on) begin
          heater_q = 1'b0;
        end else if (!cfg_auto) begin
          step_slot(cfg_duty, 1'b0);
        end else if (int'(c.temp) > int'(c.setp) + int'(cfg_hyst)) begin
          // over the band: keep duty, slot still moves, heater off
          step_slot(auto_duty_q, 1'b1);
        end else begin
          err = int'(c.setp) - int'(c.temp);
          if (err > int'(DUTY_MAX)) err = int'(DUTY_MAX);
          else if (err < int'(DUTY_MIN)) err = int'(DUTY_MIN);
          auto_duty_q = err[DUTY_W-1:0];
          step_slot(auto_duty_q, 1'b0);
        end
      end
      default: ;
    endcase
    s.heater_on      = heater_q;
    s.cooking_active = cook_on;
    s.buzzer         = buzz_on;
    s.hours_left     = tmr_hours;
    s.minutes_left   = tmr_minutes;
    s.seconds_left   = tmr_seconds;
    s.duty_now       = cfg_auto ? auto_duty_q : cfg_duty;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // driver: predicts on accept, then presents the next item or idles
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        drv_taken.op      = cmd_ch.op;
        drv_taken.hours   = cmd_ch.load_hours;
        drv_taken.minutes = cmd_ch.load_minutes;
        drv_taken.seconds = cmd_ch.load_seconds;
        drv_taken.temp    = cmd_ch.measured_temp;
        drv_taken.setp    = cmd_ch.setpoint_temp;
        predict_status(drv_taken, drv_status);
        status_expected.push_back(drv_status);
        accepted_total++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_next = cmd_backlog.pop_front();
          cmd_ch.valid         <= 1'b1;
          cmd_ch.op            <= drv_next.op;
          cmd_ch.load_hours    <= drv_next.hours;
          cmd_ch.load_minutes  <= drv_next.minutes;
          cmd_ch.load_seconds  <= drv_next.seconds;
          cmd_ch.measured_temp <= drv_next.temp;
          cmd_ch.setpoint_temp <= drv_next.setp;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: scores each status item against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      status_ch.ready <= 1'b0;
    end else begin
      if (status_ch.valid && status_ch.ready) begin
        if (status_expected.size() == 0) begin
          $error("status item with nothing expected");
          mismatches++;
        end else begin
          mon_want = status_expected.pop_front();
          check_field("heater_on", mon_want.heater_on, status_ch.heater_on);
          check_field("cooking_active", mon_want.cooking_active, status_ch.cooking_active);
          check_field("buzzer", mon_want.buzzer, status_ch.buzzer);
          check_field("hours_left", mon_want.hours_left, status_ch.hours_left);
          check_field("minutes_left", mon_want.minutes_left, status_ch.minutes_left);
          check_field("seconds_left", mon_want.seconds_left, status_ch.seconds_left);
          check_field("duty_now", mon_want.duty_now, status_ch.duty_now);
        end
      end
      status_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (status_ch.valid && status_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic push_cmd(input logic [OP_W-1:0] op, input int h, input int m, input int s,
                          input int t, input int sp);
    cmd_item_t c;
    c.op      = op;
    c.hours   = h[HOURS_W-1:0];
    c.minutes = m[MS_W-1:0];
    c.seconds = s[MS_W-1:0];
    c.temp    = t[TEMP_W-1:0];
    c.setp    = sp[TEMP_W-1:0];
    cmd_backlog.push_back(c);
    queued_total++;
  endtask

  function automatic cmd_item_t random_cmd();
    cmd_item_t c;
    int pick;
    int t;
    c.op      = OP_SEC;
    c.hours   = HOURS_W'($urandom);
    c.minutes = MS_W'($urandom);
    c.seconds = MS_W'($urandom);
    c.temp    = TEMP_W'($urandom);
    c.setp    = TEMP_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 12) begin
      c.op = OP_LOAD;
      pick = $urandom_range(99);
      // mostly short times so countdowns expire often
      if (pick < 60) begin
        c.hours   = '0;
        c.minutes = '0;
        c.seconds = MS_W'($urandom_range(20));
      end else if (pick < 85) begin
        c.hours   = '0;
        c.minutes = MS_W'($urandom_range(3));
        c.seconds = MS_W'($urandom_range(59));
      end
    end else if (pick < 24) begin
      c.op = OP_START;
    end else if (pick < 28) begin
      c.op = OP_STOP;
    end else if (pick < 58) begin
      c.op = OP_SEC;
    end else if (pick < 97) begin
      c.op = OP_HEAT;
      if ($urandom_range(99) < 70) begin
        c.setp = TEMP_W'($urandom_range(300));
        t = int'(c.setp) + int'($urandom_range(30)) - 15;
        if (t < 0) t = 0;
        c.temp = t[TEMP_W-1:0];
      end
    end else begin
      c.op = OP_W'($urandom_range(7, int'(OP_HEAT) + 1));
    end
    return c;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
  endtask

  task automatic apply_settings(input logic a, input logic [HYST_W-1:0] h,
                                input logic [DUTY_W-1:0] d);
    write_reg(REG_AUTO_MODE, CFG_DATA_W'(a));
    write_reg(REG_HYSTERESIS, CFG_DATA_W'(h));
    write_reg(REG_MANUAL_DUTY, d);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_auto = a;
    cfg_hyst = h;
    cfg_duty = d;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (accepted_total != queued_total || status_expected.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_phase(input logic a, input logic [HYST_W-1:0] h,
                           input logic [DUTY_W-1:0] d, input int send_pct,
                           input int recv_pct);
    apply_settings(a, h, d);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      cmd_backlog.push_back(random_cmd());
      queued_total++;
    end
    wait_drained();
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = REG_AUTO_MODE;
    cfg_data             = '0;
    cmd_ch.valid         = 1'b0;
    cmd_ch.op            = OP_LOAD;
    cmd_ch.load_hours    = '0;
    cmd_ch.load_minutes  = '0;
    cmd_ch.load_seconds  = '0;
    cmd_ch.measured_temp = '0;
    cmd_ch.setpoint_temp = '0;
    status_ch.ready      = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed, manual mode
    apply_settings(1'b0, 3'd0, 4'd10);
    push_cmd(OP_START, 0, 0, 0, 0, 0);          // zero time: ignored
    push_cmd(OP_SEC, 0, 0, 0, 0, 0);            // timer not running
    push_cmd(OP_HEAT, 0, 0, 0, 100, 200);       // not cooking
    for (int k = int'(OP_HEAT) + 1; k < 8; k++)
      push_cmd(OP_W'(k), 7, 63, 63, 511, 511);  // unused ops
    push_cmd(OP_LOAD, 7, 63, 63, 0, 0);         // saturates
    push_cmd(OP_LOAD, 0, 0, 1, 0, 0);
    push_cmd(OP_START, 0, 0, 0, 0, 0);
    push_cmd(OP_HEAT, 0, 0, 0, 20, 200);        // idle slot keeps level
    push_cmd(OP_HEAT, 0, 0, 0, 20, 200);
    push_cmd(OP_SEC, 0, 0, 0, 0, 0);
    push_cmd(OP_SEC, 0, 0, 0, 0, 0);            // expiry, buzzer
    push_cmd(OP_START, 0, 0, 0, 0, 0);          // zero time, buzzer stays
    push_cmd(OP_LOAD, 1, 0, 0, 0, 0);
    push_cmd(OP_START, 0, 0, 0, 0, 0);          // clears buzzer
    push_cmd(OP_SEC, 0, 0, 0, 0, 0);            // borrow through hours
    push_cmd(OP_LOAD, 0, 1, 0, 0, 0);           // load while cooking
    push_cmd(OP_SEC, 0, 0, 0, 0, 0);            // borrow from minutes
    push_cmd(OP_STOP, 0, 0, 0, 0, 0);
    wait_drained();

    // directed, auto mode
    apply_settings(1'b1, 3'd5, 4'd10);
    push_cmd(OP_LOAD, 5, 59, 59, 0, 0);
    push_cmd(OP_START, 0, 0, 0, 0, 0);
    push_cmd(OP_HEAT, 0, 0, 0, 300, 0);         // above band, forced off
    push_cmd(OP_HEAT, 0, 0, 0, 0, 300);         // clamp high
    push_cmd(OP_HEAT, 0, 0, 0, 200, 200);       // clamp low
    push_cmd(OP_HEAT, 0, 0, 0, 205, 200);       // edge of band
    push_cmd(OP_HEAT, 0, 0, 0, 206, 200);       // just above band
    push_cmd(OP_HEAT, 0, 0, 0, 511, 511);
    push_cmd(OP_STOP, 0, 0, 0, 0, 0);
    wait_drained();

    run_phase(1'b0, 3'd0, 4'd0,  0,  0);
    run_phase(1'b0, 3'd7, 4'd10, 48, 0);
    run_phase(1'b1, 3'd0, 4'd4,  0,  48);
    run_phase(1'b1, 3'd5, 4'd15, 8,  8);
    run_phase(1'b0, 3'd3, 4'd5,  0,  0);
    run_phase(1'b1, 3'd7, 4'd0,  48, 0);
    run_phase(1'b0, 3'd1, 4'd7,  0,  48);
    run_phase(1'b1, 3'd2, 4'd10, 8,  8);

    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
rtl/cthd_pkg.sv
rtl/cthd_cmd_if.sv
rtl/cthd_status_if.sv
rtl/cthd_heater.sv
rtl/cook_timer_heater_duty_control.sv
test/cook_timer_heater_duty_control_test.sv
